// File: sv/unsigned_interval_xor_bounds_assert.svh
// Assertion macros for the interval XOR bounds module
`ifndef UNSIGNED_INTERVAL_XOR_BOUNDS_ASSERT_SVH
`define UNSIGNED_INTERVAL_XOR_BOUNDS_ASSERT_SVH

// Property must hold on every rising clock edge outside reset
`define UIXB_ASSERT(label, clk, rstn, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rstn) (prop)) else $error(msg);

// Consequent must hold in the cycle after the antecedent
`define UIXB_ASSERT_NEXT(label, clk, rstn, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
        else $error(msg);

`endif

// File: sv/uixb_pkg.sv
package uixb_pkg;

    // Field width of the ports
    localparam int unsigned FIELD_W = 32;

    // Pipeline stage count
    localparam int unsigned STAGES = 3;

endpackage

// File: sv/uixb_bound.sv
// One interval bound rule: scans from the top bit down for the first bit
// where a bound can move, then combines the bounds.
module uixb_bound
    import uixb_pkg::*;
#(
    parameter int unsigned WIDTH = 32,
    parameter int unsigned KIND  = 0   // 0 minOR, 1 maxOR, 2 minAND, 3 maxAND
) (
    input  logic [WIDTH-1:0] a,
    input  logic [WIDTH-1:0] b,
    input  logic [WIDTH-1:0] c,
    input  logic [WIDTH-1:0] d,
    output logic [WIDTH-1:0] y
);

    logic [WIDTH-1:0] aa, bb, cc, dd;
    logic [WIDTH-1:0] m, t1, t2;
    logic             done;

    // priority scan, first movable bit wins
    always_comb begin
        aa   = a;
        bb   = b;
        cc   = c;
        dd   = d;
        done = 1'b0;
        for (int i = WIDTH - 1; i >= 0; i--) begin
            m = '0;
            m[i] = 1'b1;
            if (!done) begin
                case (KIND)
                    0: begin
                        t1 = (a | m) & (-m);
                        t2 = (c | m) & (-m);
                        if (~a[i] & c[i]) begin
                            if (t1 <= b) begin aa = t1; done = 1'b1; end
                        end else if (a[i] & ~c[i]) begin
                            if (t2 <= d) begin cc = t2; done = 1'b1; end
                        end
                    end
                    1: begin
                        t1 = (b - m) | (m - 1'b1);
                        t2 = (d - m) | (m - 1'b1);
                        if (b[i] & d[i]) begin
                            if (t1 >= a) begin bb = t1; done = 1'b1; end
                            else if (t2 >= c) begin dd = t2; done = 1'b1; end
                        end
                    end
                    2: begin
                        t1 = (a | m) & (-m);
                        t2 = (c | m) & (-m);
                        if (~a[i] & ~c[i]) begin
                            if (t1 <= b) begin aa = t1; done = 1'b1; end
                            else if (t2 <= d) begin cc = t2; done = 1'b1; end
                        end
                    end
                    default: begin
                        t1 = (b & ~m) | (m - 1'b1);
                        t2 = (d & ~m) | (m - 1'b1);
                        if (b[i] & ~d[i]) begin
                            if (t1 >= a) begin bb = t1; done = 1'b1; end
                        end else if (~b[i] & d[i]) begin
                            if (t2 >= c) begin dd = t2; done = 1'b1; end
                        end
                    end
                endcase
            end else begin
                t1 = '0;
                t2 = '0;
            end
        end
    end

    // combine the adjusted bounds
    always_comb begin
        case (KIND)
            0:       y = aa | cc;
            1:       y = bb | dd;
            2:       y = aa & cc;
            default: y = bb & dd;
        endcase
    end

endmodule

// File: sv/unsigned_interval_xor_bounds.sv
// Unsigned interval XOR bounds: for intervals [lo_a,hi_a] and [lo_b,hi_b]
// gives [lo_out,hi_out] holding x ^ y for all x, y in them, using the
// min/max OR and AND bound scans in a sound but loose composition. Inverted
// intervals are not checked. Three pipeline stages: stage 1 runs the
// minAND/minOR/maxAND scans on the input bounds, stage 2 the maxOR merges
// for lo, hi_x and hi_y, stage 3 the final maxAND. One item is taken each
// cycle unless the result side stalls, which holds every stage in place; an
// item moves through the stage 1, stage 2 and stage 3 registers in order.
module unsigned_interval_xor_bounds
    import uixb_pkg::*;
#(
    parameter int unsigned WIDTH = 32
) (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               s_valid,
    output logic               s_ready,
    input  logic [FIELD_W-1:0] s_lo_a,
    input  logic [FIELD_W-1:0] s_hi_a,
    input  logic [FIELD_W-1:0] s_lo_b,
    input  logic [FIELD_W-1:0] s_hi_b,
    output logic               m_valid,
    input  logic               m_ready,
    output logic [FIELD_W-1:0] m_lo_out,
    output logic [FIELD_W-1:0] m_hi_out
);

`include "unsigned_interval_xor_bounds_assert.svh"

    logic [WIDTH-1:0] la, ha, lb, hb;
    logic [WIDTH-1:0] low_p, low_q, or_part, and_a_nb, and_na_b;
    logic [WIDTH-1:0] low, hi_x, hi_y, high;
    logic [WIDTH-1:0] zero;
    logic             adv;

    logic [STAGES-1:0]  vld_reg, vld_next;
    logic [WIDTH-1:0]   p_reg, q_reg, o_reg, ab_reg, nb_reg;
    logic [WIDTH-1:0]   low_reg, hx_reg, hy_reg;
    logic [FIELD_W-1:0] lo_out_reg, hi_out_reg;

    assign zero = '0;
    assign la = WIDTH'(s_lo_a);
    assign ha = WIDTH'(s_hi_a);
    assign lb = WIDTH'(s_lo_b);
    assign hb = WIDTH'(s_hi_b);

    // whole pipe moves when the last stage is empty or drains
    assign adv     = !vld_reg[STAGES-1] || m_ready;
    assign s_ready = adv;

    // stage 1 scans
    uixb_bound #(.WIDTH(WIDTH), .KIND(2)) u_p (.a(la), .b(ha), .c(~hb), .d(~lb), .y(low_p));
    uixb_bound #(.WIDTH(WIDTH), .KIND(2)) u_q (.a(~ha), .b(~la), .c(lb), .d(hb), .y(low_q));
    uixb_bound #(.WIDTH(WIDTH), .KIND(0)) u_o (.a(~ha), .b(~la), .c(lb), .d(hb), .y(or_part));
    uixb_bound #(.WIDTH(WIDTH), .KIND(3)) u_ab (.a(la), .b(ha), .c(~hb), .d(~lb), .y(and_a_nb));
    uixb_bound #(.WIDTH(WIDTH), .KIND(3)) u_nb (.a(~ha), .b(~la), .c(lb), .d(hb), .y(and_na_b));

    // stage 2 merges
    uixb_bound #(.WIDTH(WIDTH), .KIND(1)) u_lo (.a(zero), .b(p_reg), .c(zero), .d(q_reg), .y(low));
    uixb_bound #(.WIDTH(WIDTH), .KIND(1)) u_hx (.a(zero), .b(o_reg), .c(zero), .d(ab_reg), .y(hi_x));
    uixb_bound #(.WIDTH(WIDTH), .KIND(1)) u_hy (.a(zero), .b(nb_reg), .c(zero), .d(ab_reg), .y(hi_y));

    // stage 3 final bound
    uixb_bound #(.WIDTH(WIDTH), .KIND(3)) u_hi (.a(zero), .b(hx_reg), .c(zero), .d(hy_reg), .y(high));

    // valid bits follow the data
    always_comb begin
        vld_next = {vld_reg[STAGES-2:0], s_valid};
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            vld_reg <= '0;
        end else if (adv) begin
            vld_reg <= vld_next;
        end
    end

    // payload stages
    always_ff @(posedge aclk) begin
        if (adv) begin
            p_reg      <= low_p;
            q_reg      <= low_q;
            o_reg      <= or_part;
            ab_reg     <= and_a_nb;
            nb_reg     <= and_na_b;
            low_reg    <= low;
            hx_reg     <= hi_x;
            hy_reg     <= hi_y;
            lo_out_reg <= FIELD_W'(low_reg);
            hi_out_reg <= FIELD_W'(high);
        end
    end

    assign m_valid  = vld_reg[STAGES-1];
    assign m_lo_out = lo_out_reg;
    assign m_hi_out = hi_out_reg;

    `UIXB_ASSERT(a_ready_tracks_out, aclk, aresetn, s_ready == (!m_valid || m_ready), "ready mismatch")
    `UIXB_ASSERT_NEXT(a_stall_holds, aclk, aresetn, m_valid && !m_ready, m_valid && $stable(m_lo_out) && $stable(m_hi_out), "stalled result changed")
    `UIXB_ASSERT_NEXT(a_pipe_fill, aclk, aresetn, s_valid && s_ready, vld_reg[0], "stage 1 valid lost")

endmodule

// File: tb/tb_top.sv
`timescale 1ns / 100ps

module tb_top;
    import uixb_pkg::*;

    typedef logic [FIELD_W-1:0] word_t;

    typedef struct {
        word_t lo_a;
        word_t hi_a;
        word_t lo_b;
        word_t hi_b;
    } bounds_item_t;

    typedef struct {
        word_t lo;
        word_t hi;
    } xor_range_t;

    // Directed row: item plus optional typed-in answer
    typedef struct {
        bounds_item_t item;
        bit           known;
        xor_range_t   answer;
    } directed_row_t;

    localparam int N_RANDOM   = 800;
    localparam int WATCH_LIMIT = 2000;
    localparam word_t ONES    = '1;
    localparam word_t TOPB    = word_t'(1) << (FIELD_W - 1);

    logic  aclk;
    logic  aresetn;
    logic  s_valid;
    logic  s_ready;
    word_t s_lo_a, s_hi_a, s_lo_b, s_hi_b;
    logic  m_valid;
    logic  m_ready;
    word_t m_lo_out, m_hi_out;

    xor_range_t expected_ranges[$];
    int         n_errors;
    int         idle_cycles;
    int         rx_wait;
    bit         stim_done;

    unsigned_interval_xor_bounds dut (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_valid  (s_valid),
        .s_ready  (s_ready),
        .s_lo_a   (s_lo_a),
        .s_hi_a   (s_hi_a),
        .s_lo_b   (s_lo_b),
        .s_hi_b   (s_hi_b),
        .m_valid  (m_valid),
        .m_ready  (m_ready),
        .m_lo_out (m_lo_out),
        .m_hi_out (m_hi_out)
    );

    initial begin
        aclk = 1'b0;
        forever #5 aclk = ~aclk;
    end

    // Bound scans on FIELD_W-bit words
    function automatic word_t min_or_bound(word_t a, word_t b, word_t c, word_t d);
        word_t m, t;
        for (int i = FIELD_W - 1; i >= 0; i--) begin
            m = word_t'(1) << i;
            if ((~a & c & m) != 0) begin
                t = (a | m) & (-m);
                if (t <= b) begin a = t; break; end
            end else if ((a & ~c & m) != 0) begin
                t = (c | m) & (-m);
                if (t <= d) begin c = t; break; end
            end
        end
        return a | c;
    endfunction

    function automatic word_t max_or_bound(word_t a, word_t b, word_t c, word_t d);
        word_t m, t;
        for (int i = FIELD_W - 1; i >= 0; i--) begin
            m = word_t'(1) << i;
            if ((b & d & m) != 0) begin
                t = (b - m) | (m - 1);
                if (t >= a) begin b = t; break; end
                t = (d - m) | (m - 1);
                if (t >= c) begin d = t; break; end
            end
        end
        return b | d;
    endfunction

    function automatic word_t min_and_bound(word_t a, word_t b, word_t c, word_t d);
        word_t m, t;
        for (int i = FIELD_W - 1; i >= 0; i--) begin
            m = word_t'(1) << i;
            if ((~a & ~c & m) != 0) begin
                t = (a | m) & (-m);
                if (t <= b) begin a = t; break; end
                t = (c | m) & (-m);
                if (t <= d) begin c = t; break; end
            end
        end
        return a & c;
    endfunction

    function automatic word_t max_and_bound(word_t a, word_t b, word_t c, word_t d);
        word_t m, t;
        for (int i = FIELD_W - 1; i >= 0; i--) begin
            m = word_t'(1) << i;
            if ((b & ~d & m) != 0) begin
                t = (b & ~m) | (m - 1);
                if (t >= a) begin b = t; break; end
            end else if ((~b & d & m) != 0) begin
                t = (d & ~m) | (m - 1);
                if (t >= c) begin d = t; break; end
            end
        end
        return b & d;
    endfunction

    // Loose XOR interval composed from the four bound scans
    function automatic xor_range_t xor_interval(bounds_item_t it);
        xor_range_t r;
        word_t p, q, or_part, a_nb, na_b, hx, hy;
        p       = min_and_bound(it.lo_a, it.hi_a, ~it.hi_b, ~it.lo_b);
        q       = min_and_bound(~it.hi_a, ~it.lo_a, it.lo_b, it.hi_b);
        r.lo    = max_or_bound('0, p, '0, q);
        or_part = min_or_bound(~it.hi_a, ~it.lo_a, it.lo_b, it.hi_b);
        a_nb    = max_and_bound(it.lo_a, it.hi_a, ~it.hi_b, ~it.lo_b);
        hx      = max_or_bound('0, or_part, '0, a_nb);
        na_b    = max_and_bound(~it.hi_a, ~it.lo_a, it.lo_b, it.hi_b);
        hy      = max_or_bound('0, na_b, '0, a_nb);
        r.hi    = max_and_bound('0, hx, '0, hy);
        return r;
    endfunction

    function automatic word_t rand_word();
        case ($urandom_range(0, 3))
            0: return word_t'($urandom_range(0, 255));
            1: return ONES - word_t'($urandom_range(0, 255));
            default: return word_t'($urandom);
        endcase
    endfunction

    // Ordered interval pair, mostly well formed, some inverted
    function automatic bounds_item_t rand_item();
        bounds_item_t it;
        word_t x, y;
        x = rand_word();
        y = rand_word();
        if (x > y && $urandom_range(0, 9) != 0) begin it.lo_a = y; it.hi_a = x; end
        else begin it.lo_a = x; it.hi_a = y; end
        x = rand_word();
        y = ($urandom_range(0, 2) == 0) ? x + word_t'($urandom_range(0, 15)) : rand_word();
        if (x > y && $urandom_range(0, 9) != 0) begin it.lo_b = y; it.hi_b = x; end
        else begin it.lo_b = x; it.hi_b = y; end
        return it;
    endfunction

    // Valid drops only when a gap follows, so back to back items see one update
    task automatic send_item(bounds_item_t it, int gap);
        if (gap > 0) begin
            s_valid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_valid <= 1'b1;
        s_lo_a  <= it.lo_a;
        s_hi_a  <= it.hi_a;
        s_lo_b  <= it.lo_b;
        s_hi_b  <= it.hi_b;
        do @(posedge aclk); while (!s_ready);
    endtask

    // Stimulus: directed table, then random intervals
    initial begin
        directed_row_t rows[$];
        directed_row_t row;
        bounds_item_t  it;
        s_valid   = 1'b0;
        s_lo_a    = '0;
        s_hi_a    = '0;
        s_lo_b    = '0;
        s_hi_b    = '0;
        aresetn   = 1'b0;
        stim_done = 1'b0;
        repeat (9) @(posedge aclk);
        aresetn <= 1'b1;

        // Points and full ranges with obvious answers
        rows.push_back('{'{'0, '0, '0, '0}, 1'b1, '{'0, '0}});
        rows.push_back('{'{ONES, ONES, ONES, ONES}, 1'b1, '{'0, '0}});
        rows.push_back('{'{ONES, ONES, '0, '0}, 1'b1, '{ONES, ONES}});
        rows.push_back('{'{'0, ONES, '0, ONES}, 1'b1, '{'0, ONES}});
        rows.push_back('{'{TOPB, TOPB, '0, '0}, 1'b1, '{TOPB, TOPB}});
        // Predictor-checked rows: mixed, inverted, single bits
        rows.push_back('{'{'0, ONES, TOPB, TOPB}, 1'b0, '{'0, '0}});
        rows.push_back('{'{32'h0000_00F0, 32'h0000_0F0F, 32'h1234_5678, 32'h8765_4321},
                         1'b0, '{'0, '0}});
        rows.push_back('{'{ONES, '0, '0, ONES}, 1'b0, '{'0, '0}});
        rows.push_back('{'{32'h8000_0001, 32'h0000_0001, 32'hFFFF_0000, 32'h0000_FFFF},
                         1'b0, '{'0, '0}});
        rows.push_back('{'{32'h5555_5555, 32'hAAAA_AAAA, 32'hAAAA_AAAA, 32'h5555_5555},
                         1'b0, '{'0, '0}});
        rows.push_back('{'{32'h7FFF_FFFF, TOPB, 32'h7FFF_FFFF, TOPB}, 1'b0, '{'0, '0}});
        rows.push_back('{'{32'd3, 32'd9, 32'd4, 32'd6}, 1'b0, '{'0, '0}});
        for (int i = 0; i < rows.size(); i++) begin
            row = rows[i];
            expected_ranges.push_back(row.known ? row.answer : xor_interval(row.item));
            send_item(row.item, $urandom_range(0, 5));
        end

        for (int i = 0; i < N_RANDOM; i++) begin
            // Drain fully once mid-run
            if (i == N_RANDOM / 2) begin
                s_valid <= 1'b0;
                while (expected_ranges.size() != 0) @(posedge aclk);
            end
            it = rand_item();
            expected_ranges.push_back(xor_interval(it));
            // Burst stretch: no sender gap
            if (i >= 100 && i < 160)
                send_item(it, 0);
            else
                send_item(it, $urandom_range(0, 5));
        end
        s_valid   <= 1'b0;
        stim_done = 1'b1;
    end

    // Result side: ready held low for a drawn number of cycles after each item
    always @(posedge aclk) begin
        int n;
        if (!aresetn) begin
            m_ready <= 1'b0;
            rx_wait <= $urandom_range(0, 5);
        end else if (m_valid && m_ready) begin
            n = $urandom_range(0, 5);
            rx_wait <= n;
            m_ready <= (n == 0);
        end else if (rx_wait != 0) begin
            rx_wait <= rx_wait - 1;
            m_ready <= (rx_wait == 1);
        end else begin
            m_ready <= 1'b1;
        end
    end

    // Compare results in order
    always @(posedge aclk) begin
        xor_range_t want;
        if (aresetn && m_valid && m_ready) begin
            if (expected_ranges.size() == 0) begin
                $display("%0t: unexpected item lo=%h hi=%h", $time, m_lo_out, m_hi_out);
                n_errors++;
            end else begin
                want = expected_ranges.pop_front();
                if (m_lo_out !== want.lo) begin
                    $display("%0t: lo_out expected %h actual %h", $time, want.lo, m_lo_out);
                    n_errors++;
                end
                if (m_hi_out !== want.hi) begin
                    $display("%0t: hi_out expected %h actual %h", $time, want.hi, m_hi_out);
                    n_errors++;
                end
            end
        end
    end

    // Watchdog on cycles with no handshake
    always @(posedge aclk) begin
        if (!aresetn || (s_valid && s_ready) || (m_valid && m_ready))
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
    end

    initial begin
        n_errors    = 0;
        idle_cycles = 0;
        fork
            begin
                wait (stim_done && expected_ranges.size() == 0);
                repeat (STAGES + 10) @(posedge aclk);
            end
            begin
                wait (idle_cycles >= WATCH_LIMIT);
                n_errors++;
                $display("%0t: timeout", $time);
            end
        join_any
        if (n_errors == 0)
            $display("DONE: 0 errors");
        else
            $display("DONE: errors detected");
        $finish;
    end

endmodule

// File: unsigned_interval_xor_bounds.f
+incdir+sv
sv/uixb_pkg.sv
sv/uixb_bound.sv
sv/unsigned_interval_xor_bounds.sv
tb/tb_top.sv
